### design/text_pre_token_splitter_top_assert.svh
// Assertion macros for the text pre-token splitter.
// Used by text_pre_token_splitter_top.sv; expects clk and rst in scope.
`ifndef TEXT_PRE_TOKEN_SPLITTER_TOP_ASSERT_SVH
`define TEXT_PRE_TOKEN_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication
`define TPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/tps_pkg.sv
// Package for the text pre-token splitter: kind codes, hold codes,
// result word type and byte classification. No dependencies.
`default_nettype none

package tps_pkg;

  // Token kinds
  localparam logic [2:0] KIND_LETTERS = 3'd0;
  localparam logic [2:0] KIND_DIGITS  = 3'd1;
  localparam logic [2:0] KIND_SPACE   = 3'd2;
  localparam logic [2:0] KIND_CONTR   = 3'd3;
  localparam logic [2:0] KIND_OTHER   = 3'd4;
  localparam logic [2:0] KIND_NONE    = 3'd5;

  // Hold state codes
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_APOS = 2'd1;
  localparam logic [1:0] HELD_PAIR = 2'd2;

  localparam logic [7:0] APOS = 8'h27;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_start;
    logic [2:0] token_kind;
    logic       end_of_text;
    logic       run_last;
  } res_t;

  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [2:0] k;
    k = KIND_OTHER;
    if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)) k = KIND_LETTERS;
    else if (b >= 8'hc2 && b <= 8'hc3) k = KIND_LETTERS;
    else if (b >= 8'h80 && b <= 8'hbf) k = KIND_LETTERS;
    else if (b >= 8'h30 && b <= 8'h39) k = KIND_DIGITS;
    else if (b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d) k = KIND_SPACE;
    return k;
  endfunction

  // Result word for a byte handled as a plain run/other byte
  function automatic res_t plain_res(input logic [7:0] b, input logic [2:0] open_k);
    res_t r;
    logic [2:0] k;
    k = classify(b);
    r.out_byte    = b;
    r.token_kind  = k;
    r.token_start = (k == KIND_OTHER) ? 1'b1 : (open_k != k);
    r.end_of_text = 1'b0;
    r.run_last    = 1'b0;
    return r;
  endfunction

  // Open run after a plain byte
  function automatic logic [2:0] plain_next(input logic [7:0] b);
    logic [2:0] k;
    k = classify(b);
    return (k == KIND_OTHER) ? KIND_NONE : k;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic st, input logic [2:0] k);
    res_t r;
    r.out_byte    = b;
    r.token_start = st;
    r.token_kind  = k;
    r.end_of_text = 1'b0;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### design/tps_ifs.sv
// Handshake interfaces for the splitter's input and result channels.
// Depends on nothing; carries valid, ready and the word's fields.
`default_nettype none

interface tps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;
  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface tps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       token_start;
  logic [2:0] token_kind;
  logic       end_of_text;
  logic       run_last;
  modport source (output valid, output out_byte, output token_start, output token_kind,
                  output end_of_text, output run_last, input ready);
  modport sink   (input valid, input out_byte, input token_start, input token_kind,
                  input end_of_text, input run_last, output ready);
endinterface

`default_nettype wire

### design/text_pre_token_splitter_top.sv
// An accepted byte's first result word is registered and offered the next cycle.
// Throughput: one byte per cycle while each byte gives at most one word and the
// receiver is ready; a completed contraction gives two or three words, a broken hold
// one to three, which the single port drains one per ready cycle before the next lands.
// Reset (rst, synchronous): clears the hold, the open token and the result buffer.
// Depends on tps_pkg, tps_ifs.sv and text_pre_token_splitter_top_assert.svh.
`default_nettype none
`include "text_pre_token_splitter_top_assert.svh"

module text_pre_token_splitter_top (
  input wire logic  clk,
  input wire logic  rst,
  tps_in_if.sink    in_word,
  tps_out_if.source out_word
);
  import tps_pkg::*;

  // Splitter state
  logic [1:0] held_count;
  logic [7:0] held_letter;
  logic [2:0] open_kind;

  // Result buffer: grp[0] is the word on offer, cnt words remain
  res_t       grp [0:2];
  logic [1:0] cnt;

  logic [1:0] held_count_next;
  logic [7:0] held_letter_next;
  logic [2:0] open_kind_next;
  res_t       slots [0:2];
  logic [1:0] n;

  logic in_fire, out_fire;
  logic [7:0] b;
  logic       lst;
  logic [7:0] third;
  logic [2:0] ok;

  assign b        = in_word.in_byte;
  assign lst      = in_word.last;
  assign out_fire = out_word.valid && out_word.ready;
  assign in_fire  = in_word.valid && in_word.ready;

  assign in_word.ready = (cnt == 2'd0) || ((cnt == 2'd1) && out_word.ready);

  assign third = (held_letter == 8'h72 || held_letter == 8'h76) ? 8'h65 : 8'h6c;

  // Results and next state for the byte on the input
  always_comb begin
    ok               = open_kind;
    held_count_next  = HELD_NONE;
    held_letter_next = held_letter;
    n                = 2'd0;
    for (int i = 0; i < 3; i++) slots[i] = mk_res(8'h00, 1'b0, KIND_OTHER);

    case (held_count)
      HELD_NONE: begin
        if (b == APOS && !lst) begin
          held_count_next = HELD_APOS;
        end else begin
          slots[0] = plain_res(b, ok);
          ok       = plain_next(b);
          n        = 2'd1;
        end
      end
      HELD_APOS: begin
        if (b == 8'h73 || b == 8'h74 || b == 8'h6d || b == 8'h64) begin
          slots[0] = mk_res(APOS, 1'b1, KIND_CONTR);
          slots[1] = mk_res(b, 1'b0, KIND_CONTR);
          ok       = KIND_NONE;
          n        = 2'd2;
        end else if ((b == 8'h72 || b == 8'h76 || b == 8'h6c) && !lst) begin
          held_count_next  = HELD_PAIR;
          held_letter_next = b;
        end else begin
          slots[0] = mk_res(APOS, 1'b1, KIND_OTHER);
          ok       = KIND_NONE;
          n        = 2'd1;
          if (b == APOS && !lst) begin
            held_count_next = HELD_APOS;
          end else begin
            slots[1] = plain_res(b, ok);
            ok       = plain_next(b);
            n        = 2'd2;
          end
        end
      end
      HELD_PAIR: begin
        held_letter_next = 8'h00;
        if (b == third) begin
          slots[0] = mk_res(APOS, 1'b1, KIND_CONTR);
          slots[1] = mk_res(held_letter, 1'b0, KIND_CONTR);
          slots[2] = mk_res(b, 1'b0, KIND_CONTR);
          ok       = KIND_NONE;
          n        = 2'd3;
        end else begin
          slots[0] = mk_res(APOS, 1'b1, KIND_OTHER);
          slots[1] = plain_res(held_letter, KIND_NONE);
          ok       = plain_next(held_letter);
          n        = 2'd2;
          if (b == APOS && !lst) begin
            held_count_next = HELD_APOS;
          end else begin
            slots[2] = plain_res(b, ok);
            ok       = plain_next(b);
            n        = 2'd3;
          end
        end
      end
      default: begin
        held_count_next = HELD_NONE;
      end
    endcase

    // End of text flushes everything
    if (lst) begin
      held_count_next  = HELD_NONE;
      held_letter_next = 8'h00;
      ok               = KIND_NONE;
    end
    open_kind_next = ok;

    // Mark the final word of this byte
    for (int i = 0; i < 3; i++) begin
      slots[i].run_last    = (n == 2'(i + 1));
      slots[i].end_of_text = (n == 2'(i + 1)) && lst;
    end
  end

  // State and result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count  <= HELD_NONE;
      held_letter <= 8'h00;
      open_kind   <= KIND_NONE;
      cnt         <= 2'd0;
    end else begin
      if (in_fire) begin
        held_count  <= held_count_next;
        held_letter <= held_letter_next;
        open_kind   <= open_kind_next;
        cnt         <= n;
      end else if (out_fire) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) grp[i] <= slots[i];
    end else if (out_fire) begin
      grp[0] <= grp[1];
      grp[1] <= grp[2];
    end
  end

  // Result port
  assign out_word.valid       = (cnt != 2'd0);
  assign out_word.out_byte    = grp[0].out_byte;
  assign out_word.token_start = grp[0].token_start;
  assign out_word.token_kind  = grp[0].token_kind;
  assign out_word.end_of_text = grp[0].end_of_text;
  assign out_word.run_last    = grp[0].run_last;

  // Checks
  `TPS_ASSERT_NOW(a_pair_letter, held_count == HELD_PAIR, held_letter == 8'h72 || held_letter == 8'h76 || held_letter == 8'h6c, "held letter is not r, v or l")
  `TPS_ASSERT_NOW(a_run_last_cnt, out_word.valid, out_word.run_last == (cnt == 2'd1), "run_last out of step with buffer count")
  `TPS_ASSERT_NOW(a_eot_is_run_last, out_word.valid && out_word.end_of_text, out_word.run_last, "end_of_text on a word that is not the last of its byte")
  `TPS_ASSERT_NEXT(a_last_flush, in_fire && in_word.last, held_count == HELD_NONE && open_kind == KIND_NONE && cnt != 2'd0, "last byte left state behind")
  `TPS_ASSERT_NOW(a_hold_code, 1'b1, held_count != 2'd3, "hold count out of range")

endmodule

`default_nettype wire

### dv/text_pre_token_splitter_checker.sv
// Checker for the text pre-token splitter: watches the byte and result channels,
// predicts the result words and compares them. Depends on tps_pkg and tps_ifs.sv.
`default_nettype none

module text_pre_token_splitter_checker (
  input wire logic clk,
  input wire logic rst,
  tps_in_if        in_mon,
  tps_out_if       out_mon,
  output int       fail_total,
  output int       words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  // Predictor state: hold depth, held letter, kind of the open run
  logic [1:0] held_cnt;
  logic [7:0] held_ltr;
  logic [2:0] run_kind;

  res_t step_words[$];
  res_t expected_words[$];
  int   word_idx;

  task automatic report_mismatch(input string msg);
    $display("ERROR: result word %0d: %s", word_idx, msg);
    fail_total++;
  endtask

  function automatic logic [2:0] byte_kind(input logic [7:0] b);
    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return KIND_LETTERS;
    if ((b >= 8'h80 && b <= 8'hbf) || b == 8'hc2 || b == 8'hc3) return KIND_LETTERS;
    if (b >= "0" && b <= "9") return KIND_DIGITS;
    if (b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d) return KIND_SPACE;
    return KIND_OTHER;
  endfunction

  task automatic add_word(input logic [7:0] b, input logic st, input logic [2:0] k);
    res_t w;
    w.out_byte    = b;
    w.token_start = st;
    w.token_kind  = k;
    w.end_of_text = 1'b0;
    w.run_last    = 1'b0;
    step_words.insert(step_words.size(), w);
  endtask

  // Byte outside any contraction: joins or opens a run, or stands alone
  task automatic add_run_byte(input logic [7:0] b);
    logic [2:0] k;
    k = byte_kind(b);
    if (k == KIND_OTHER) begin
      add_word(b, 1'b1, KIND_OTHER);
      run_kind = KIND_NONE;
    end else begin
      add_word(b, run_kind != k, k);
      run_kind = k;
    end
  endtask

  // Byte seen with nothing held; an apostrophe starts a hold unless it ends the text
  task automatic take_fresh(input logic [7:0] b, input logic lst);
    if (b == APOS && !lst) held_cnt = HELD_APOS;
    else add_run_byte(b);
  endtask

  task automatic release_apos();
    add_word(APOS, 1'b1, KIND_OTHER);
    run_kind = KIND_NONE;
  endtask

  // Expected words for one accepted byte
  task automatic split_byte(input logic [7:0] b, input logic lst);
    logic [7:0] ltr, third;
    step_words.delete();
    if (held_cnt == HELD_NONE) begin
      take_fresh(b, lst);
    end else if (held_cnt == HELD_APOS) begin
      held_cnt = HELD_NONE;
      if (b == "s" || b == "t" || b == "m" || b == "d") begin
        add_word(APOS, 1'b1, KIND_CONTR);
        add_word(b, 1'b0, KIND_CONTR);
        run_kind = KIND_NONE;
      end else if ((b == "r" || b == "v" || b == "l") && !lst) begin
        held_cnt = HELD_PAIR;
        held_ltr = b;
      end else begin
        release_apos();
        take_fresh(b, lst);
      end
    end else begin
      ltr = held_ltr;
      third = (ltr == "r" || ltr == "v") ? "e" : "l";
      held_cnt = HELD_NONE;
      held_ltr = 8'h00;
      if (b == third) begin
        add_word(APOS, 1'b1, KIND_CONTR);
        add_word(ltr, 1'b0, KIND_CONTR);
        add_word(b, 1'b0, KIND_CONTR);
        run_kind = KIND_NONE;
      end else begin
        release_apos();
        add_run_byte(ltr);
        take_fresh(b, lst);
      end
    end
    // End of text flushes everything and closes the open run
    if (lst) begin
      held_cnt = HELD_NONE;
      held_ltr = 8'h00;
      run_kind = KIND_NONE;
    end
    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].run_last    = 1'b1;
      step_words[step_words.size() - 1].end_of_text = lst;
    end
    foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
  endtask

  // Predict on accepted bytes, compare accepted result words
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      held_cnt = HELD_NONE;
      held_ltr = 8'h00;
      run_kind = KIND_NONE;
      expected_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) split_byte(in_mon.in_byte, in_mon.last);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("byte 0x%02h arrived with no word expected",
                                    out_mon.out_byte));
        end else begin
          want = expected_words.pop_front();
          if (out_mon.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte expected 0x%02h, got 0x%02h",
                                      want.out_byte, out_mon.out_byte));
          if (out_mon.token_start !== want.token_start)
            report_mismatch($sformatf("token_start expected %0b, got %0b",
                                      want.token_start, out_mon.token_start));
          if (out_mon.token_kind !== want.token_kind)
            report_mismatch($sformatf("token_kind expected %0d, got %0d",
                                      want.token_kind, out_mon.token_kind));
          if (out_mon.end_of_text !== want.end_of_text)
            report_mismatch($sformatf("end_of_text expected %0b, got %0b",
                                      want.end_of_text, out_mon.end_of_text));
          if (out_mon.run_last !== want.run_last)
            report_mismatch($sformatf("run_last expected %0b, got %0b",
                                      want.run_last, out_mon.run_last));
        end
        word_idx++;
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

`default_nettype wire

### dv/text_pre_token_splitter_top_tb.sv
// Top of the splitter testbench: clock, reset, byte stimulus, receiver stalls,
// watchdog and verdict. Depends on tps_pkg, tps_ifs.sv and the checker module.
`default_nettype none

module text_pre_token_splitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } text_byte_t;

  logic clk;
  logic rst;
  int   fail_total;
  int   words_pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;

  text_byte_t text_q[$];

  tps_in_if  in_word();
  tps_out_if out_word();

  text_pre_token_splitter_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .out_word (out_word)
  );

  text_pre_token_splitter_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_word),
    .out_mon       (out_word),
    .fail_total    (fail_total),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_word.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic l);
    text_byte_t t;
    t.b = b;
    t.l = l;
    text_q.insert(text_q.size(), t);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 3))
      0:       return 8'(8'h61 + $urandom_range(0, 25));
      1:       return 8'(8'h41 + $urandom_range(0, 25));
      2:       return 8'($urandom_range(8'h80, 8'hbf));
      default: return 8'($urandom_range(8'hc2, 8'hc3));
    endcase
  endfunction

  function automatic logic [7:0] pick_other();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h00, 8'h08));
      1:       return 8'($urandom_range(8'h21, 8'h2f));
      2:       return 8'($urandom_range(8'hc4, 8'hff));
      default: return 8'($urandom_range(8'hc0, 8'hc1));
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0:       return " ";
      1:       return 8'h09;
      2:       return 8'h0a;
      default: return 8'h0d;
    endcase
  endfunction

  // Apostrophe followed by a correct contraction tail
  task automatic add_contraction();
    add_byte(APOS, 1'b0);
    case ($urandom_range(0, 6))
      0: add_byte("s", 1'b0);
      1: add_byte("t", 1'b0);
      2: add_byte("m", 1'b0);
      3: add_byte("d", 1'b0);
      4: begin
        add_byte("r", 1'b0);
        add_byte("e", 1'b0);
      end
      5: begin
        add_byte("v", 1'b0);
        add_byte("e", 1'b0);
      end
      default: begin
        add_byte("l", 1'b0);
        add_byte("l", 1'b0);
      end
    endcase
  endtask

  // Apostrophe alone, with a random byte, or with r/v/l and a random byte
  task automatic add_broken_contraction();
    add_byte(APOS, 1'b0);
    case ($urandom_range(0, 2))
      0: ;
      1: add_byte(8'($urandom_range(0, 255)), 1'b0);
      default: begin
        case ($urandom_range(0, 2))
          0:       add_byte("r", 1'b0);
          1:       add_byte("v", 1'b0);
          default: add_byte("l", 1'b0);
        endcase
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endtask

  // Random text built from runs, contractions and noise, with texts ending at random
  task automatic gen_random_text(input int want);
    int stop_at;
    stop_at = text_q.size() + want;
    while (text_q.size() < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1:    repeat ($urandom_range(1, 5)) add_byte(pick_letter(), 1'b0);
        2:       repeat ($urandom_range(1, 4)) add_byte(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
        3:       repeat ($urandom_range(1, 3)) add_byte(pick_space(), 1'b0);
        4, 5:    add_contraction();
        6:       add_broken_contraction();
        7:       add_byte(8'($urandom_range(0, 255)), 1'b0);
        default: add_byte(pick_other(), 1'b0);
      endcase
      if ($urandom_range(0, 7) == 0) text_q[$].l = 1'b1;
    end
    text_q[$].l = 1'b1;
  endtask

  // Drive text bytes [from, upto) with random sender gaps
  task automatic send_text(input int from, input int upto);
    for (int i = from; i < upto; i++) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        in_word.valid <= 1'b0;
        @(posedge clk);
      end
      in_word.valid   <= 1'b1;
      in_word.in_byte <= text_q[i].b;
      in_word.last    <= text_q[i].l;
      do @(posedge clk); while (!in_word.ready);
    end
  endtask

  task automatic drain_results();
    in_word.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  initial begin
    int n_dir, quarter;
    rst             <= 1'b1;
    in_word.valid   <= 1'b0;
    in_word.in_byte <= 8'h00;
    in_word.last    <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, each class, contractions, mismatches, flushes
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte("A", 1'b0);
    add_byte("z", 1'b0);
    add_byte(8'hc3, 1'b0);
    add_byte("9", 1'b0);
    add_byte(8'h0a, 1'b0);
    add_byte(APOS, 1'b0);
    add_byte("s", 1'b0);
    add_byte(APOS, 1'b0);
    add_byte("d", 1'b0);
    add_byte(APOS, 1'b0);
    add_byte("r", 1'b0);
    add_byte("e", 1'b0);
    // held letter broken by a plain byte
    add_byte(APOS, 1'b0);
    add_byte("l", 1'b0);
    add_byte("x", 1'b0);
    // held letter broken by a new apostrophe, which then forms 't
    add_byte(APOS, 1'b0);
    add_byte("v", 1'b0);
    add_byte(APOS, 1'b0);
    add_byte("t", 1'b0);
    // held apostrophe flushed by a last r
    add_byte(APOS, 1'b0);
    add_byte("r", 1'b1);
    // apostrophe that ends the text
    add_byte(APOS, 1'b1);
    // 'll closing a text
    add_byte(APOS, 1'b0);
    add_byte("l", 1'b0);
    add_byte("l", 1'b1);
    n_dir = text_q.size();
    send_text(0, n_dir);

    gen_random_text(200);
    quarter = (text_q.size() - n_dir) / 4;

    // No idling
    send_text(n_dir, n_dir + quarter);
    // Sender mostly idle, then hold off until every result is out
    idle_pct = 83;
    send_text(n_dir + quarter, n_dir + 2 * quarter);
    drain_results();
    // Receiver mostly stalled
    idle_pct  = 0;
    stall_pct = 83;
    send_text(n_dir + 2 * quarter, n_dir + 3 * quarter);
    // Light idling on both sides
    idle_pct  = 14;
    stall_pct = 14;
    send_text(n_dir + 3 * quarter, text_q.size());

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_total == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
